[src/alsir_pkg.sv]
// types and codes shared by the ordered list block and its checker
`default_nettype none

package alsir_pkg;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int ELEM_W   = 32;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_SEARCH = 2'd0;
    localparam cmd_t CMD_INSERT = 2'd1;
    localparam cmd_t CMD_REMOVE = 2'd2;
    localparam cmd_t CMD_VIEW   = 2'd3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK        = 3'd0;
    localparam status_t STATUS_NOT_FOUND = 3'd1;
    localparam status_t STATUS_BAD_POS   = 3'd2;
    localparam status_t STATUS_FULL      = 3'd3;
    localparam status_t STATUS_EMPTY     = 3'd4;

    typedef struct packed {
        cmd_t                      command;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_t;

    typedef struct packed {
        status_t                  status;
        logic [COUNT_W-1:0]       found_position;
        logic [COUNT_W-1:0]       removed_count;
        logic signed [ELEM_W-1:0] element;
        logic [COUNT_W-1:0]       list_size;
        logic                     last;
    } out_t;

endpackage

`default_nettype wire

[src/array_list_search_insert_remove.sv]
// ordered list with search, insert, remove-all and view over a one-read, one-write entry memory
//
// Usage: commands arrive on the s_ channel (valid/ready), one word per command;
// results leave on the m_ channel (valid/ready) from an output register.
// Search, insert and remove give one result word with last set; view gives one
// word per stored entry (last on the final one), or a single empty-status word.
// Command flow, with n entries stored:
//   search    scans up to n entries and stops at the first match
//   remove    scans all n entries, one memory read per cycle, and writes each kept entry back
//   insert    entries from the top down to the insert slot are moved up, one per cycle
//   view      each entry is read, then loaded into the output register
//   rejected or empty-list commands go straight to their result word
// The entry memory has a registered read port; its single read port sets the
// pace of every scan. s_ready is high only between commands, so one command is
// worked at a time, but a new command is taken while the last result still sits
// in the output register. A stalled receiver holds the result register and
// pauses view between entries. Reset (aresetn low, synchronous) empties the list
// and drops any pending result; the entry memory itself is not cleared.
`default_nettype none

module array_list_search_insert_remove
    import alsir_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW1 = POS_W + 1;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_SHIFT = 7'b0000100,
        ST_PUT   = 7'b0001000,
        ST_VREAD = 7'b0010000,
        ST_VEMIT = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         kept_reg, kept_next;
    logic [CW-1:0]         left_reg, left_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_idx_reg, pend_idx_next;
    out_t                  res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    logic                  slot_free;
    logic signed [63:0]    in_wide;
    logic [DATA_WIDTH-1:0] in_val;
    logic signed [63:0]    el_wide;
    logic [PW1-1:0]        pos_ext;
    logic [PW1-1:0]        pos_lim;
    logic                  pos_bad;
    logic [AW-1:0]         pos_idx;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;

    // value is fitted to the entry width by sign extension or truncation
    assign in_wide = 64'(s_data.value);
    assign in_val  = in_wide[DATA_WIDTH-1:0];
    assign el_wide = 64'(signed'(rd_data_reg));

    assign pos_ext = {1'b0, s_data.position};
    assign pos_lim = PW1'(count_reg) + PW1'(1);
    assign pos_bad = (s_data.position == '0) || (pos_ext > pos_lim);
    assign pos_idx = AW'(s_data.position - POS_W'(1));

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        kept_next     = kept_reg;
        left_next     = left_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_re        = 1'b0;
        mem_raddr     = idx_reg[AW-1:0];
        mem_we        = 1'b0;
        mem_waddr     = kept_reg[AW-1:0];
        mem_wdata     = rd_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next           = s_data.command;
                    val_next           = in_val;
                    idx_next           = '0;
                    kept_next          = '0;
                    pend_next          = 1'b0;
                    res_next           = '0;
                    res_next.last      = 1'b1;
                    res_next.list_size = COUNT_W'(count_reg);
                    case (s_data.command)
                        CMD_SEARCH, CMD_REMOVE: begin
                            if (count_reg == '0) begin
                                res_next.status = STATUS_EMPTY;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_INSERT: begin
                            if (pos_bad) begin
                                res_next.status = STATUS_BAD_POS;
                                state_next      = ST_DONE;
                            end else if (count_reg == CAP_CNT) begin
                                res_next.status = STATUS_FULL;
                                state_next      = ST_DONE;
                            end else begin
                                pos_next   = pos_idx;
                                left_next  = count_reg - CW'(pos_idx);
                                idx_next   = count_reg - CW'(1);
                                state_next = ST_SHIFT;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                res_next.status = STATUS_EMPTY;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_VREAD;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // reads run one ahead of the compare on the registered data
                if (idx_reg != count_reg) begin
                    mem_re   = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                pend_next     = (idx_reg != count_reg);
                pend_idx_next = idx_reg[AW-1:0];
                if (pend_reg) begin
                    if (cmd_reg == CMD_SEARCH) begin
                        if (rd_data_reg == val_reg) begin
                            res_next.found_position = COUNT_W'(pend_idx_reg) + COUNT_W'(1);
                            state_next              = ST_DONE;
                        end
                    end else if (rd_data_reg != val_reg) begin
                        // compaction write never reaches the entry being read
                        mem_we    = 1'b1;
                        mem_waddr = kept_reg[AW-1:0];
                        mem_wdata = rd_data_reg;
                        kept_next = kept_reg + CW'(1);
                    end
                end else if (idx_reg == count_reg) begin
                    if (cmd_reg == CMD_SEARCH) begin
                        res_next.status = STATUS_NOT_FOUND;
                    end else begin
                        count_next             = kept_reg;
                        res_next.removed_count = COUNT_W'(count_reg - kept_reg);
                        res_next.list_size     = COUNT_W'(kept_reg);
                        res_next.status        = (kept_reg == count_reg) ? STATUS_NOT_FOUND
                                                                         : STATUS_OK;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT: begin
                // move entries up one place, from the top down to the insert slot
                if (left_reg != '0) begin
                    mem_re    = 1'b1;
                    idx_next  = idx_reg - CW'(1);
                    left_next = left_reg - CW'(1);
                end
                pend_next     = (left_reg != '0);
                pend_idx_next = idx_reg[AW-1:0];
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_idx_reg + AW'(1);
                    mem_wdata = rd_data_reg;
                end else if (left_reg == '0) begin
                    state_next = ST_PUT;
                end
            end

            ST_PUT: begin
                mem_we             = 1'b1;
                mem_waddr          = pos_reg;
                mem_wdata          = val_reg;
                count_next         = count_reg + CW'(1);
                res_next.list_size = COUNT_W'(count_reg) + COUNT_W'(1);
                state_next         = ST_DONE;
            end

            ST_VREAD: begin
                mem_re     = 1'b1;
                state_next = ST_VEMIT;
            end

            ST_VEMIT: begin
                if (slot_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next           = '0;
                    m_data_next.element   = el_wide[ELEM_W-1:0];
                    m_data_next.list_size = COUNT_W'(count_reg);
                    m_data_next.last      = ((idx_reg + CW'(1)) == count_reg);
                    if ((idx_reg + CW'(1)) == count_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_VREAD;
                    end
                end
            end

            ST_DONE: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        kept_reg     <= kept_next;
        left_reg     <= left_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

[src/alsir_chk.sv]
// port-level checker for the ordered list block, bound to its top level
`default_nettype none

module alsir_chk
    import alsir_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // every failing command ends its run in one word
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STATUS_OK) |-> m_data.last)
        else $error("error status without last");

    // a reported match lies inside the list
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.found_position != '0) |->
            (m_data.status == STATUS_OK) && (m_data.found_position <= m_data.list_size))
        else $error("found position outside list");

    // size never passes capacity, and a removal leaves room
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.list_size <= COUNT_W'(CAPACITY)) &&
            ((m_data.removed_count == '0) ||
             (32'(m_data.removed_count) + 32'(m_data.list_size) <= CAPACITY)))
        else $error("list size out of range");

endmodule

bind array_list_search_insert_remove alsir_chk #(.CAPACITY(CAPACITY)) u_alsir_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[tb/alsir_list_checker.sv]
// checker for the ordered list block: tracks the list, predicts result words and compares them
`timescale 1ns / 1ps

module alsir_list_checker
    import alsir_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   words_pending,
    output int   list_size_now,
    output int   cmd_count,
    output int   word_count,
    output int   peak_size,
    output int   full_hits
);

    logic signed [ELEM_W-1:0] shadow_list[$];
    out_t                     expected_words[$];

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // update the list for one command and queue the words it should produce
    task automatic predict_command(input in_t w);
        logic signed [ELEM_W-1:0] kept[$];
        out_t                     r;
        int                       n;
        int                       pos;
        int                       hit;
        n   = shadow_list.size();
        pos = int'(w.position);
        hit = -1;
        r   = '0;
        r.last = 1'b1;
        case (w.command)
            CMD_SEARCH: begin
                if (n == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    for (int i = n - 1; i >= 0; i--)
                        if (shadow_list[i] == w.value) hit = i;
                    if (hit < 0) begin
                        r.status = STATUS_NOT_FOUND;
                    end else begin
                        r.status         = STATUS_OK;
                        r.found_position = COUNT_W'(hit + 1);
                    end
                end
            end
            CMD_INSERT: begin
                // bad position is checked ahead of fullness
                if (pos == 0 || pos > n + 1) begin
                    r.status = STATUS_BAD_POS;
                end else if (n >= CAPACITY) begin
                    r.status = STATUS_FULL;
                    full_hits++;
                end else begin
                    shadow_list.push_back(w.value);
                    for (int i = n; i > pos - 1; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos-1] = w.value;
                    r.status = STATUS_OK;
                end
            end
            CMD_REMOVE: begin
                if (n == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    foreach (shadow_list[i])
                        if (shadow_list[i] != w.value) kept.push_back(shadow_list[i]);
                    r.removed_count = COUNT_W'(n - kept.size());
                    r.status = (kept.size() == n) ? STATUS_NOT_FOUND : STATUS_OK;
                    shadow_list = kept;
                end
            end
            default: begin
                if (n == 0) r.status = STATUS_EMPTY;
            end
        endcase
        r.list_size = COUNT_W'(shadow_list.size());
        if (w.command == CMD_VIEW && n != 0) begin
            foreach (shadow_list[i]) begin
                r.status  = STATUS_OK;
                r.element = shadow_list[i];
                r.last    = (i == n - 1);
                expected_words.push_back(r);
            end
        end else begin
            expected_words.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            shadow_list.delete();
            expected_words.delete();
            fail_count = 0;
            cmd_count  = 0;
            word_count = 0;
            peak_size  = 0;
            full_hits  = 0;
        end else begin
            if (m_valid && m_ready) begin
                word_count++;
                if (expected_words.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with nothing expected, got %p", $time, m_data);
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", 32'(want.status), 32'(m_data.status));
                    check_field("found_position", 32'(want.found_position),
                                32'(m_data.found_position));
                    check_field("removed_count", 32'(want.removed_count),
                                32'(m_data.removed_count));
                    check_field("element", want.element, m_data.element);
                    check_field("list_size", 32'(want.list_size), 32'(m_data.list_size));
                    check_field("last", 32'(want.last), 32'(m_data.last));
                end
            end
            if (s_valid && s_ready) begin
                cmd_count++;
                predict_command(s_data);
            end
        end
        words_pending = expected_words.size();
        list_size_now = shadow_list.size();
        if (list_size_now > peak_size) peak_size = list_size_now;
    end

endmodule

[tb/tb_array_list_search_insert_remove.sv]
// testbench top: stimulus, handshake idling and verdict for the ordered list block
`timescale 1ns / 1ps

module tb_array_list_search_insert_remove;
    import alsir_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 85;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    int fail_count;
    int words_pending;
    int list_size_now;
    int cmd_count;
    int word_count;
    int peak_size;
    int full_hits;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    int   cycle_count    = 0;

    logic signed [VALUE_W-1:0] value_pool[8];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    array_list_search_insert_remove #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (32)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    alsir_list_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .list_size_now (list_size_now),
        .cmd_count     (cmd_count),
        .word_count    (word_count),
        .peak_size     (peak_size),
        .full_hits     (full_hits)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("array_list_search_insert_remove: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_cmd(input cmd_t c, input logic signed [VALUE_W-1:0] v,
                            input logic [POS_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_data.command   = c;
        s_data.value     = v;
        s_data.position  = p;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (words_pending != 0) @(negedge aclk);
    endtask

    task automatic random_command(input int insert_pct, input int remove_pct);
        int                        n;
        int                        roll;
        int                        sel;
        logic signed [VALUE_W-1:0] v;
        logic [POS_W-1:0]          p;
        n    = list_size_now;
        roll = $urandom_range(99);
        v    = ($urandom_range(99) < 65) ? value_pool[$urandom_range(7)] : $urandom;
        p    = POS_W'($urandom_range(127));
        if (roll < insert_pct) begin
            sel = $urandom_range(99);
            if (sel < 8)
                p = $urandom_range(1) ? '0 : POS_W'($urandom_range(127, n + 2));
            else if (sel < 30)
                p = POS_W'(n + 1);
            else if (sel < 45)
                p = POS_W'(1);
            else
                p = POS_W'($urandom_range(n + 1, 1));
            send_cmd(CMD_INSERT, v, p);
        end else if (roll < insert_pct + remove_pct) begin
            send_cmd(CMD_REMOVE, v, p);
        end else if ($urandom_range(99) < 65) begin
            send_cmd(CMD_SEARCH, v, p);
        end else begin
            send_cmd(CMD_VIEW, v, p);
        end
    endtask

    initial begin
        int insert_pct[4];
        int remove_pct[4];
        int send_pct[4];
        int recv_pct[4];
        insert_pct = '{55, 85, 45, 60};
        remove_pct = '{15, 4, 25, 15};
        send_pct   = '{0, 58, 0, 13};
        recv_pct   = '{0, 0, 58, 13};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty list cases, rejected positions, extremes, adjacent duplicates
        send_cmd(CMD_VIEW,   0, 0);
        send_cmd(CMD_SEARCH, 0, 0);
        send_cmd(CMD_REMOVE, 0, 0);
        send_cmd(CMD_INSERT, 1, 0);
        send_cmd(CMD_INSERT, 1, 2);
        send_cmd(CMD_INSERT, VAL_MIN, 1);
        send_cmd(CMD_INSERT, VAL_MAX, 2);
        send_cmd(CMD_INSERT, 5, 2);
        send_cmd(CMD_INSERT, 5, 2);
        send_cmd(CMD_INSERT, -1, 1);
        send_cmd(CMD_INSERT, 5, 6);
        send_cmd(CMD_INSERT, 5, 127);
        send_cmd(CMD_SEARCH, 5, 64);
        send_cmd(CMD_SEARCH, VAL_MAX, 0);
        send_cmd(CMD_SEARCH, 12345, 0);
        send_cmd(CMD_VIEW,   VAL_MIN, 127);
        send_cmd(CMD_REMOVE, 5, 0);
        send_cmd(CMD_REMOVE, 5, 0);
        send_cmd(CMD_REMOVE, VAL_MIN, 0);
        send_cmd(CMD_VIEW,   0, 0);
        send_cmd(CMD_REMOVE, -1, 0);
        send_cmd(CMD_REMOVE, VAL_MAX, 0);
        send_cmd(CMD_VIEW,   0, 0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            value_pool[0] = VAL_MIN;
            value_pool[1] = VAL_MAX;
            value_pool[2] = 0;
            value_pool[3] = -1;
            for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
            // long receiver hold-off while words keep coming, so the input backs up
            if (ph == 0) hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                random_command(insert_pct[ph], remove_pct[ph]);
            wait_drained();
        end

        s_valid = 1'b0;
        while (words_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run covered %0d commands and %0d result words under four idling mixes",
                 cmd_count, word_count);
        $display("list reached %0d entries; %0d inserts met a full list", peak_size, full_hits);
        if (fail_count == 0) begin
            $display("array_list_search_insert_remove: match");
        end else begin
            $display("array_list_search_insert_remove: mismatch");
        end
        $finish;
    end

endmodule
